// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ramp generator RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stls_pkg.sv =====
// Package for the servo linear sweep unit: command codes, controller states,
// datapath operations and the control/status structs. No dependencies.
`timescale 1ns / 1ps

package stls_pkg;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_SWEEP  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_ATTACH = 3'd4;
    localparam logic [2:0] CMD_DETACH = 3'd5;

    localparam logic [1:0] REG_MIN_ANGLE = 2'd0;
    localparam logic [1:0] REG_MAX_ANGLE = 2'd1;

    localparam logic [7:0] MIN_ANGLE_RST     = 8'd0;
    localparam logic [7:0] MAX_ANGLE_RST     = 8'd180;
    localparam logic [7:0] DEFAULT_ANGLE_RST = 8'd90;

    localparam logic [3:0] ANGLE_LAST_BIT = 4'd7;
    localparam logic [3:0] PROG_LAST_BIT  = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_T_ELAP,
        ST_T_CHECK,
        ST_A_DBL,
        ST_A_ADD,
        ST_ROUND,
        ST_P_ELAP,
        ST_P_CHECK,
        ST_P_DBL,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPLY,
        OP_ELAPSED,
        OP_SNAP,
        OP_ANGLE_INIT,
        OP_DBL,
        OP_ADD,
        OP_ROUND,
        OP_PROG_INIT,
        OP_PROG_FULL,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctl_t;

    typedef struct packed {
        logic tick_sweep;   // tick while attached and sweeping
        logic t_done;       // elapsed has reached the sweep length
        logic prog_run;     // progress needs the divide loop
        logic mag_msb;      // current multiplier bit of the angle span
    } dp_status_t;

endpackage

// ===== rtl/core/stls_datapath.sv =====
// Datapath of the servo linear sweep unit: configuration, angle and timing
// state, shift-subtract multiply/divide unit and result registers. Uses stls_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stls_datapath #(
    parameter int TIME_BITS    = 32,
    parameter int MIN_SWEEP_MS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic [2:0]             s_cmd,
    input  logic signed [15:0]     s_angle_request,
    input  logic [31:0]            s_duration_ms,
    input  logic [31:0]            s_now_ms,
    input  stls_pkg::dp_ctl_t      ctl,
    output stls_pkg::dp_status_t   status,
    output logic [7:0]             m_servo_angle,
    output logic                   m_write_strobe,
    output logic [7:0]             m_goal_angle,
    output logic                   m_moving,
    output logic                   m_attached,
    output logic [16:0]            m_progress_q16
);
    import stls_pkg::*;

    localparam logic [16:0] PROG_FULL = 17'h10000;

    function automatic logic [7:0] clamp_angle(logic signed [15:0] a,
                                               logic [7:0] lo, logic [7:0] hi);
        logic signed [15:0] lo_s;
        logic signed [15:0] hi_s;
        lo_s = $signed({8'd0, lo});
        hi_s = $signed({8'd0, hi});
        if (a < lo_s) return lo;
        if (a > hi_s) return hi;
        return a[7:0];
    endfunction

    // configuration
    logic [7:0]           min_reg, min_next;
    logic [7:0]           max_reg, max_next;
    // architectural state
    logic [7:0]           present_reg, present_next;
    logic [7:0]           aim_reg, aim_next;
    logic [7:0]           origin_reg, origin_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] length_reg, length_next;
    logic                 sweeping_reg, sweeping_next;
    logic                 attached_reg, attached_next;
    // captured word
    logic [2:0]           cmd_reg, cmd_next;
    logic signed [15:0]   req_reg, req_next;
    logic [31:0]          dur_reg, dur_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    // working registers
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] de_reg, de_next;
    logic [TIME_BITS-1:0] r_reg, r_next;
    logic [16:0]          q_reg, q_next;
    logic [7:0]           mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 strobe_reg, strobe_next;
    // result word
    logic [7:0]           o_angle_reg, o_angle_next;
    logic                 o_strobe_reg, o_strobe_next;
    logic [7:0]           o_goal_reg, o_goal_next;
    logic                 o_moving_reg, o_moving_next;
    logic                 o_attached_reg, o_attached_next;
    logic [16:0]          o_prog_reg, o_prog_next;

    logic [7:0]           clamped;
    logic [31:0]          dur_floor;
    logic [TIME_BITS+1:0] dbl_diff;
    logic [TIME_BITS:0]   add_diff;
    logic [TIME_BITS:0]   twice_rem;
    logic                 round_up;
    logic [8:0]           na9;

    assign clamped   = clamp_angle(req_reg, min_reg, max_reg);
    assign dur_floor = (dur_reg < 32'(MIN_SWEEP_MS)) ? 32'(MIN_SWEEP_MS) : dur_reg;
    assign dbl_diff  = {1'b0, r_reg, 1'b0} - {2'b00, length_reg};
    assign add_diff  = {1'b0, r_reg} - {1'b0, de_reg};
    assign twice_rem = {r_reg, 1'b0};
    assign round_up  = neg_reg ? (twice_rem > {1'b0, length_reg})
                               : (twice_rem >= {1'b0, length_reg});
    assign na9 = neg_reg ? ({1'b0, origin_reg} - q_reg[8:0] - {8'd0, round_up})
                         : ({1'b0, origin_reg} + q_reg[8:0] + {8'd0, round_up});

    assign status.tick_sweep = (cmd_reg == CMD_TICK) && attached_reg && sweeping_reg;
    assign status.t_done     = (length_reg == '0) || (elapsed_reg >= length_reg);
    assign status.prog_run   = sweeping_reg && (length_reg != '0) &&
                               (elapsed_reg < length_reg);
    assign status.mag_msb    = mag_reg[7];

    always_comb begin
        min_next        = min_reg;
        max_next        = max_reg;
        present_next    = present_reg;
        aim_next        = aim_reg;
        origin_next     = origin_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        sweeping_next   = sweeping_reg;
        attached_next   = attached_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        dur_next        = dur_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        de_next         = de_reg;
        r_next          = r_reg;
        q_next          = q_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        strobe_next     = strobe_reg;
        o_angle_next    = o_angle_reg;
        o_strobe_next   = o_strobe_reg;
        o_goal_next     = o_goal_reg;
        o_moving_next   = o_moving_reg;
        o_attached_next = o_attached_reg;
        o_prog_next     = o_prog_reg;

        // the default angle register only matters at reset, so its writes are dropped
        if (cfg_we) begin
            case (cfg_index)
                REG_MIN_ANGLE: min_next = cfg_wdata;
                REG_MAX_ANGLE: max_next = cfg_wdata;
                default: ;
            endcase
        end

        case (ctl.op)
            OP_LOAD: begin
                cmd_next    = s_cmd;
                req_next    = s_angle_request;
                dur_next    = s_duration_ms;
                now_next    = TIME_BITS'(s_now_ms);
                strobe_next = 1'b0;
            end
            OP_APPLY: begin
                case (cmd_reg)
                    CMD_ATTACH: begin
                        present_next  = clamped;
                        aim_next      = clamped;
                        origin_next   = clamped;
                        sweeping_next = 1'b0;
                        attached_next = 1'b1;
                        strobe_next   = 1'b1;
                    end
                    CMD_SET: begin
                        if (attached_reg) begin
                            sweeping_next = 1'b0;
                            present_next  = clamped;
                            aim_next      = clamped;
                            strobe_next   = 1'b1;
                        end
                    end
                    CMD_SWEEP: begin
                        if (attached_reg) begin
                            aim_next = clamped;
                            if (clamped == present_reg) begin
                                sweeping_next = 1'b0;
                            end else begin
                                origin_next   = present_reg;
                                start_next    = now_reg;
                                length_next   = TIME_BITS'(dur_floor);
                                sweeping_next = 1'b1;
                            end
                        end
                    end
                    CMD_STOP: begin
                        if (attached_reg) begin
                            sweeping_next = 1'b0;
                            aim_next      = present_reg;
                        end
                    end
                    CMD_DETACH: begin
                        if (attached_reg) begin
                            attached_next = 1'b0;
                            sweeping_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_ELAPSED: elapsed_next = now_reg - start_reg;
            OP_SNAP: begin
                present_next  = aim_reg;
                sweeping_next = 1'b0;
                strobe_next   = 1'b1;
            end
            OP_ANGLE_INIT: begin
                r_next   = '0;
                q_next   = '0;
                de_next  = length_reg - elapsed_reg;
                neg_next = aim_reg < origin_reg;
                mag_next = (aim_reg < origin_reg) ? (origin_reg - aim_reg)
                                                  : (aim_reg - origin_reg);
            end
            OP_DBL: begin
                mag_next = {mag_reg[6:0], 1'b0};
                if (!dbl_diff[TIME_BITS+1]) begin
                    r_next = dbl_diff[TIME_BITS-1:0];
                    q_next = {q_reg[15:0], 1'b1};
                end else begin
                    r_next = {r_reg[TIME_BITS-2:0], 1'b0};
                    q_next = {q_reg[15:0], 1'b0};
                end
            end
            OP_ADD: begin
                if (!add_diff[TIME_BITS]) begin
                    r_next = add_diff[TIME_BITS-1:0];
                    q_next = q_reg + 17'd1;
                end else begin
                    r_next = r_reg + elapsed_reg;
                end
            end
            OP_ROUND: begin
                if (na9[7:0] != present_reg) begin
                    present_next = na9[7:0];
                    strobe_next  = 1'b1;
                end
            end
            OP_PROG_INIT: begin
                r_next = elapsed_reg;
                q_next = '0;
            end
            OP_PROG_FULL: q_next = PROG_FULL;
            OP_PUBLISH: begin
                o_angle_next    = present_reg;
                o_strobe_next   = strobe_reg;
                o_goal_next     = aim_reg;
                o_moving_next   = sweeping_reg;
                o_attached_next = attached_reg;
                o_prog_next     = q_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= MIN_ANGLE_RST;
            max_reg      <= MAX_ANGLE_RST;
            present_reg  <= DEFAULT_ANGLE_RST;
            aim_reg      <= DEFAULT_ANGLE_RST;
            origin_reg   <= DEFAULT_ANGLE_RST;
            start_reg    <= '0;
            length_reg   <= '0;
            sweeping_reg <= 1'b0;
            attached_reg <= 1'b0;
        end else begin
            min_reg      <= min_next;
            max_reg      <= max_next;
            present_reg  <= present_next;
            aim_reg      <= aim_next;
            origin_reg   <= origin_next;
            start_reg    <= start_next;
            length_reg   <= length_next;
            sweeping_reg <= sweeping_next;
            attached_reg <= attached_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        req_reg        <= req_next;
        dur_reg        <= dur_next;
        now_reg        <= now_next;
        elapsed_reg    <= elapsed_next;
        de_reg         <= de_next;
        r_reg          <= r_next;
        q_reg          <= q_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        strobe_reg     <= strobe_next;
        o_angle_reg    <= o_angle_next;
        o_strobe_reg   <= o_strobe_next;
        o_goal_reg     <= o_goal_next;
        o_moving_reg   <= o_moving_next;
        o_attached_reg <= o_attached_next;
        o_prog_reg     <= o_prog_next;
    end

    assign m_servo_angle  = o_angle_reg;
    assign m_write_strobe = o_strobe_reg;
    assign m_goal_angle   = o_goal_reg;
    assign m_moving       = o_moving_reg;
    assign m_attached     = o_attached_reg;
    assign m_progress_q16 = o_prog_reg;

    `ASSERT_IMPLIES(a_dbl_rem_below_len, ctl.op == OP_DBL, r_reg < length_reg, "dbl remainder out of range")
    `ASSERT_IMPLIES(a_add_rem_below_len, ctl.op == OP_ADD, r_reg < length_reg, "add remainder out of range")
    `ASSERT_IMPLIES(a_round_q_narrow, ctl.op == OP_ROUND, q_reg[16:8] == 9'd0, "angle quotient too wide")

endmodule

// ===== rtl/core/stls_ctrl.sv =====
// Controller of the servo linear sweep unit: sequences the datapath through
// command apply, angle interpolation, progress divide and result hand-off. Uses stls_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stls_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  stls_pkg::dp_status_t status,
    output stls_pkg::dp_ctl_t    ctl
);
    import stls_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctl.op       = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.op     = OP_LOAD;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                ctl.op     = OP_APPLY;
                state_next = status.tick_sweep ? ST_T_ELAP : ST_P_ELAP;
            end
            ST_T_ELAP: begin
                ctl.op     = OP_ELAPSED;
                state_next = ST_T_CHECK;
            end
            ST_T_CHECK: begin
                if (status.t_done) begin
                    ctl.op     = OP_SNAP;
                    state_next = ST_P_ELAP;
                end else begin
                    ctl.op     = OP_ANGLE_INIT;
                    cnt_next   = ANGLE_LAST_BIT;
                    state_next = ST_A_DBL;
                end
            end
            ST_A_DBL: begin
                ctl.op = OP_DBL;
                if (status.mag_msb) begin
                    state_next = ST_A_ADD;
                end else if (cnt_reg == '0) begin
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_A_ADD: begin
                ctl.op = OP_ADD;
                if (cnt_reg == '0) begin
                    state_next = ST_ROUND;
                end else begin
                    cnt_next   = cnt_reg - 4'd1;
                    state_next = ST_A_DBL;
                end
            end
            ST_ROUND: begin
                ctl.op     = OP_ROUND;
                state_next = ST_P_ELAP;
            end
            ST_P_ELAP: begin
                ctl.op     = OP_ELAPSED;
                state_next = ST_P_CHECK;
            end
            ST_P_CHECK: begin
                if (status.prog_run) begin
                    ctl.op     = OP_PROG_INIT;
                    cnt_next   = PROG_LAST_BIT;
                    state_next = ST_P_DBL;
                end else begin
                    ctl.op     = OP_PROG_FULL;
                    state_next = ST_FINISH;
                end
            end
            ST_P_DBL: begin
                ctl.op = OP_DBL;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    ctl.op       = OP_PUBLISH;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_accept_to_apply, s_valid && s_ready, state_reg == ST_APPLY, "accepted word not applied")
    `ASSERT_NEXT(a_publish_valid, state_reg == ST_FINISH && out_free, m_valid_reg, "result word not presented")
    `ASSERT_IMPLIES(a_angle_cnt_range, state_reg == ST_A_DBL || state_reg == ST_A_ADD, cnt_reg <= ANGLE_LAST_BIT, "angle bit count out of range")

endmodule

// ===== rtl/core/servo_timed_linear_sweep_unit.sv =====
// Path: accept loads the word in IDLE, then APPLY, P_ELAP, P_CHECK and FINISH; a tick
// mid-sweep adds T_ELAP and T_CHECK, then the angle steps and ROUND unless the sweep ends,
// and a word that leaves a sweep running adds the progress divide (one step per cycle in the
// shared shift-subtract unit: 8 doublings plus one add per set bit of the span for the angle,
// 16 for progress). Words are taken only in IDLE; the single divide unit sets the pace.
// Reset (aresetn low, synchronous): detached, not sweeping, all angles 90, limits 0..180.
`timescale 1ns / 1ps

module servo_timed_linear_sweep_unit #(
    parameter int TIME_BITS    = 32,
    parameter int MIN_SWEEP_MS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    // command word
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [15:0] s_angle_request,
    input  logic [31:0]        s_duration_ms,
    input  logic [31:0]        s_now_ms,
    // result word
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_servo_angle,
    output logic               m_write_strobe,
    output logic [7:0]         m_goal_angle,
    output logic               m_moving,
    output logic               m_attached,
    output logic [16:0]        m_progress_q16
);
    import stls_pkg::*;

    // Controller/datapath split: the controller owns the handshakes, the sequencing state and the
    // step counter, the datapath owns the servo and timing state and the arithmetic.
    dp_ctl_t    ctl;
    dp_status_t status;

    stls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctl     (ctl)
    );

    // Datapath: clamp and apply the command, then for a tick mid-sweep compute
    // floor(span*elapsed/length) one multiplier bit at a time with round half up,
    // and finally elapsed*65536/length for progress. The result word is held in
    // its own register so the next command word can be taken while it waits.
    stls_datapath #(
        .TIME_BITS    (TIME_BITS),
        .MIN_SWEEP_MS (MIN_SWEEP_MS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_cmd           (s_cmd),
        .s_angle_request (s_angle_request),
        .s_duration_ms   (s_duration_ms),
        .s_now_ms        (s_now_ms),
        .ctl             (ctl),
        .status          (status),
        .m_servo_angle   (m_servo_angle),
        .m_write_strobe  (m_write_strobe),
        .m_goal_angle    (m_goal_angle),
        .m_moving        (m_moving),
        .m_attached      (m_attached),
        .m_progress_q16  (m_progress_q16)
    );

endmodule

// ===== sim/servo_timed_linear_sweep_unit_tb.sv =====
// Self-checking bench for servo_timed_linear_sweep_unit: a directed table, then random command
// words under several angle limit settings; each result word is checked against a ramp model
// or a typed-in result. Depends on stls_pkg and the unit RTL only.
`timescale 1ns / 1ps

module servo_timed_linear_sweep_unit_tb;
    import stls_pkg::*;

    // Codes the package leaves out
    localparam logic [2:0]  CMD_SPARE6        = 3'd6;
    localparam logic [2:0]  CMD_SPARE7        = 3'd7;
    localparam logic [1:0]  REG_DEFAULT_ANGLE = 2'd2;

    localparam logic [16:0] PROG_FULL   = 17'd65536;
    localparam logic [31:0] MIN_SWEEP   = 32'd10;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 185;
    localparam int HOLD_CYCLES     = 500;
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 600000;

    typedef struct packed {
        logic [7:0]  angle;
        logic        strobe;
        logic [7:0]  goal;
        logic        moving;
        logic        attached;
        logic [16:0] prog;
    } servo_result_t;

    typedef struct packed {
        logic          pinned;
        servo_result_t val;
    } pinned_result_t;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] req;
        logic [31:0]        dur;
        logic [31:0]        now;
        logic               pinned;
        servo_result_t      val;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic signed [15:0] s_angle_request;
    logic [31:0]        s_duration_ms;
    logic [31:0]        s_now_ms;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_servo_angle;
    logic               m_write_strobe;
    logic [7:0]         m_goal_angle;
    logic               m_moving;
    logic               m_attached;
    logic [16:0]        m_progress_q16;

    servo_timed_linear_sweep_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_angle_request (s_angle_request),
        .s_duration_ms   (s_duration_ms),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_servo_angle   (m_servo_angle),
        .m_write_strobe  (m_write_strobe),
        .m_goal_angle    (m_goal_angle),
        .m_moving        (m_moving),
        .m_attached      (m_attached),
        .m_progress_q16  (m_progress_q16)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ramp model: limits and servo state, updated only by the word monitor
    // ------------------------------------------------------------------
    logic [7:0]  lo_lim, hi_lim;
    logic [7:0]  cur_angle, aim_angle, origin_angle;
    logic [31:0] sweep_t0, sweep_len;
    logic        sweeping, linked;

    servo_result_t  ramp_results_q[$];   // expected result words, oldest first
    pinned_result_t pinned_q[$];         // per offered word: typed-in result, if any
    stim_row_t      dir_tab[$];

    int fail_count = 0;
    int checked_count = 0;
    int strobe_count = 0;
    int cmd_seen[8];
    int cycle_count;

    // Sender- and receiver-side shaping state
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    logic [31:0] clock_ms;
    logic [31:0] dur_hint = 32'd100;
    logic        link_up = 1'b0;

    // Clamp a signed request: below the floor wins first, then the ceiling.
    function automatic logic [7:0] clamp_req(input logic signed [15:0] req);
        int a;
        a = req;
        if (a < int'(lo_lim)) return lo_lim;
        if (a > int'(hi_lim)) return hi_lim;
        return a[7:0];
    endfunction

    // Apply one command word to the model and return the result word it causes.
    function automatic servo_result_t advance_ramp(input logic [2:0] cmd,
                                                   input logic signed [15:0] req,
                                                   input logic [31:0] dur,
                                                   input logic [31:0] now);
        servo_result_t res;
        logic [7:0]    a;
        logic [31:0]   el;
        logic [63:0]   mag, prod, quo, rem, dlen;
        int            diff, na;
        res.strobe = 1'b0;
        res.prog   = PROG_FULL;
        if (cmd == CMD_ATTACH) begin
            a = clamp_req(req);
            cur_angle    = a;
            aim_angle    = a;
            origin_angle = a;
            sweeping     = 1'b0;
            linked       = 1'b1;
            res.strobe   = 1'b1;
        end else if (linked) begin
            case (cmd)
                CMD_SET: begin
                    a = clamp_req(req);
                    sweeping   = 1'b0;
                    cur_angle  = a;
                    aim_angle  = a;
                    res.strobe = 1'b1;
                end
                CMD_SWEEP: begin
                    a = clamp_req(req);
                    if (a == cur_angle) begin
                        // sweep onto the present angle: retarget only, timing untouched
                        sweeping  = 1'b0;
                        aim_angle = a;
                    end else begin
                        origin_angle = cur_angle;
                        aim_angle    = a;
                        sweep_t0     = now;
                        sweep_len    = (dur < MIN_SWEEP) ? MIN_SWEEP : dur;
                        sweeping     = 1'b1;
                    end
                end
                CMD_STOP: begin
                    sweeping  = 1'b0;
                    aim_angle = cur_angle;
                end
                CMD_DETACH: begin
                    linked   = 1'b0;
                    sweeping = 1'b0;
                end
                CMD_TICK: begin
                    if (sweeping) begin
                        el = now - sweep_t0;
                        if (sweep_len == 32'd0 || el >= sweep_len) begin
                            // end of sweep: snap and strobe even without a change
                            cur_angle  = aim_angle;
                            sweeping   = 1'b0;
                            res.strobe = 1'b1;
                        end else begin
                            diff = int'(aim_angle) - int'(origin_angle);
                            mag  = 64'(diff < 0 ? -diff : diff);
                            dlen = {32'd0, sweep_len};
                            prod = mag * {32'd0, el};
                            quo  = prod / dlen;
                            rem  = prod % dlen;
                            // round half up in angle terms: away from origin going up,
                            // toward origin going down
                            if (diff >= 0)
                                na = int'(origin_angle) + int'(quo) + ((2 * rem >= dlen) ? 1 : 0);
                            else
                                na = int'(origin_angle) - int'(quo) - ((2 * rem > dlen) ? 1 : 0);
                            if (na != int'(cur_angle)) begin
                                cur_angle  = na[7:0];
                                res.strobe = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (sweeping && sweep_len != 32'd0) begin
            el = now - sweep_t0;
            if (el < sweep_len)
                res.prog = 17'(({32'd0, el} << 16) / {32'd0, sweep_len});
        end
        res.angle    = cur_angle;
        res.goal     = aim_angle;
        res.moving   = sweeping;
        res.attached = linked;
        return res;
    endfunction

    // Word monitor: mirror resets and register writes, predict each accepted word.
    always @(posedge aclk) begin
        servo_result_t  pred;
        pinned_result_t pin;
        if (!aresetn) begin
            lo_lim       = MIN_ANGLE_RST;
            hi_lim       = MAX_ANGLE_RST;
            cur_angle    = DEFAULT_ANGLE_RST;
            aim_angle    = DEFAULT_ANGLE_RST;
            origin_angle = DEFAULT_ANGLE_RST;
            sweep_t0     = 32'd0;
            sweep_len    = 32'd0;
            sweeping     = 1'b0;
            linked       = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_ANGLE: lo_lim = cfg_wdata;
                    REG_MAX_ANGLE: hi_lim = cfg_wdata;
                    // the default angle only matters at reset, which never recurs
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pred = advance_ramp(s_cmd, s_angle_request, s_duration_ms, s_now_ms);
                pin  = pinned_q.pop_front();
                ramp_results_q.push_back(pin.pinned ? pin.val : pred);
                cmd_seen[s_cmd]++;
            end
        end
    end

    // Result checker: compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        servo_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_servo_angle, m_write_strobe, m_goal_angle, m_moving, m_attached,
                    m_progress_q16};
            checked_count++;
            strobe_count += int'(got.strobe);
            if (ramp_results_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = ramp_results_q.pop_front();
                if (got.angle !== want.angle) begin
                    $error("servo_angle: expected %0d, got %0d", want.angle, got.angle);
                    fail_count++;
                end
                if (got.strobe !== want.strobe) begin
                    $error("write_strobe: expected %0d, got %0d", want.strobe, got.strobe);
                    fail_count++;
                end
                if (got.goal !== want.goal) begin
                    $error("goal_angle: expected %0d, got %0d", want.goal, got.goal);
                    fail_count++;
                end
                if (got.moving !== want.moving) begin
                    $error("moving: expected %0d, got %0d", want.moving, got.moving);
                    fail_count++;
                end
                if (got.attached !== want.attached) begin
                    $error("attached: expected %0d, got %0d", want.attached, got.attached);
                    fail_count++;
                end
                if (got.prog !== want.prog) begin
                    $error("progress_q16: expected %0d, got %0d", want.prog, got.prog);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold once armed so the unit fills up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic stim_row_t plain_row(input logic [2:0] cmd, input logic signed [15:0] req,
                                            input logic [31:0] dur, input logic [31:0] now);
        stim_row_t r;
        r.cmd    = cmd;
        r.req    = req;
        r.dur    = dur;
        r.now    = now;
        r.pinned = 1'b0;
        r.val    = '0;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input logic [2:0] cmd,
                                             input logic signed [15:0] req,
                                             input logic [31:0] dur, input logic [31:0] now,
                                             input logic [7:0] angle, input logic strobe,
                                             input logic [7:0] goal, input logic moving,
                                             input logic attached, input logic [16:0] prog);
        stim_row_t r;
        r        = plain_row(cmd, req, dur, now);
        r.pinned = 1'b1;
        r.val    = '{angle, strobe, goal, moving, attached, prog};
        return r;
    endfunction

    // Offer one command word; hold it until the unit takes it.
    task automatic offer_word(input logic [2:0] cmd, input logic signed [15:0] req,
                              input logic [31:0] dur, input logic [31:0] now,
                              input logic pinned, input servo_result_t val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_cmd           <= cmd;
        s_angle_request <= req;
        s_duration_ms   <= dur;
        s_now_ms        <= now;
        s_valid         <= 1'b1;
        pinned_q.push_back('{pinned, val});
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every expected result word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ramp_results_q.size() != 0) @(posedge aclk);
    endtask

    task automatic program_limits(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [7:0] dflt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_ANGLE;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_MAX_ANGLE;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= REG_DEFAULT_ANGLE;
        cfg_wdata <= dflt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly legal angles, with out-of-range and full 16-bit requests mixed in.
    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(400, 181));
            2:       return 16'(-int'($urandom_range(200, 1)));
            3:       return 16'sd0;
            4:       return 16'sd180;
            default: return 16'($urandom_range(180));
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(19))
            0, 1:    return $urandom_range(9);
            2:       return $urandom;
            3:       return $urandom_range(50000000, 100000);
            default: return $urandom_range(2000, 10);
        endcase
    endfunction

    // Build one random word. Most words are ticks walking time through a sweep;
    // the rest retarget, stop, reattach, detach, or are pure noise.
    task automatic roll_word(output logic [2:0] cmd, output logic signed [15:0] req,
                             output logic [31:0] dur, output logic [31:0] now);
        int          pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        req  = pick_angle();
        dur  = pick_duration();
        cmd  = CMD_TICK;
        if (!link_up && pick < 70) begin
            cmd = CMD_ATTACH;
        end else if (pick < 4) begin
            cmd      = 3'($urandom_range(7));
            req      = 16'($urandom);
            dur      = $urandom;
            clock_ms = $urandom;
        end else if (pick < 9) begin
            cmd = CMD_ATTACH;
        end else if (pick < 11) begin
            cmd = CMD_DETACH;
        end else if (pick < 17) begin
            cmd = CMD_SET;
        end else if (pick < 29) begin
            cmd = CMD_SWEEP;
            // start some sweeps just short of the time wrap
            if ($urandom_range(7) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
            dur_hint = (dur < MIN_SWEEP) ? MIN_SWEEP : dur;
        end else if (pick < 32) begin
            cmd = CMD_STOP;
        end else begin
            case ($urandom_range(19))
                0:       clock_ms = $urandom;
                1:       clock_ms = clock_ms - $urandom_range(100, 1);
                2:       clock_ms = clock_ms + dur_hint + $urandom_range(5);
                default: begin
                    step     = dur_hint / 6 + 1;
                    clock_ms = clock_ms + $urandom_range(step);
                end
            endcase
        end
        if (cmd == CMD_ATTACH)
            link_up = 1'b1;
        else if (cmd == CMD_DETACH)
            link_up = 1'b0;
        now = clock_ms;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_row_t          r;
        logic [2:0]         cmd;
        logic signed [15:0] req;
        logic [31:0]        dur, now;
        logic [7:0]         lo, hi;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_MIN_ANGLE;
        cfg_wdata       = 8'd0;
        s_valid         = 1'b0;
        s_cmd           = CMD_TICK;
        s_angle_request = 16'sd0;
        s_duration_ms   = 32'd0;
        s_now_ms        = 32'd0;
        clock_ms        = $urandom;

        // Directed table. Limits are 0..180 throughout.
        // detached: tick, set and a spare code change nothing
        dir_tab.push_back(pinned_row(CMD_TICK, 16'sd0, 32'd0, 32'd0,
                                     8'd90, 1'b0, 8'd90, 1'b0, 1'b0, PROG_FULL));
        dir_tab.push_back(pinned_row(CMD_SET, 16'sd10, 32'd0, 32'hFFFF_FFFF,
                                     8'd90, 1'b0, 8'd90, 1'b0, 1'b0, PROG_FULL));
        dir_tab.push_back(pinned_row(CMD_SPARE6, 16'sh7FFF, 32'hFFFF_FFFF, 32'd5,
                                     8'd90, 1'b0, 8'd90, 1'b0, 1'b0, PROG_FULL));
        // attach clamps both ways
        dir_tab.push_back(pinned_row(CMD_ATTACH, 16'sh8000, 32'd0, 32'd0,
                                     8'd0, 1'b1, 8'd0, 1'b0, 1'b1, PROG_FULL));
        dir_tab.push_back(pinned_row(CMD_ATTACH, 16'sh7FFF, 32'd0, 32'd0,
                                     8'd180, 1'b1, 8'd180, 1'b0, 1'b1, PROG_FULL));
        dir_tab.push_back(pinned_row(CMD_SET, 16'sd45, 32'd0, 32'd0,
                                     8'd45, 1'b1, 8'd45, 1'b0, 1'b1, PROG_FULL));
        // zero duration raised to the minimum; halfway tick; repeat tick; end snap
        dir_tab.push_back(pinned_row(CMD_SWEEP, 16'sd135, 32'd0, 32'd1000,
                                     8'd45, 1'b0, 8'd135, 1'b1, 1'b1, 17'd0));
        dir_tab.push_back(pinned_row(CMD_TICK, 16'sd0, 32'd0, 32'd1005,
                                     8'd90, 1'b1, 8'd135, 1'b1, 1'b1, 17'd32768));
        dir_tab.push_back(plain_row(CMD_TICK, 16'sd0, 32'd0, 32'd1005));
        dir_tab.push_back(pinned_row(CMD_TICK, 16'sd0, 32'd0, 32'd1010,
                                     8'd135, 1'b1, 8'd135, 1'b0, 1'b1, PROG_FULL));
        // sweep onto the present angle only retargets
        dir_tab.push_back(pinned_row(CMD_SWEEP, 16'sd135, 32'd50, 32'd2000,
                                     8'd135, 1'b0, 8'd135, 1'b0, 1'b1, PROG_FULL));
        // longest sweep, started across the time wrap
        dir_tab.push_back(plain_row(CMD_SWEEP, 16'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
        dir_tab.push_back(plain_row(CMD_TICK, 16'sd0, 32'd0, 32'h0000_0010));
        dir_tab.push_back(plain_row(CMD_STOP, 16'sd0, 32'd0, 32'h0000_0011));
        // time running backwards reads as a huge elapsed: snap
        dir_tab.push_back(plain_row(CMD_SWEEP, 16'sd180, 32'd7, 32'd500));
        dir_tab.push_back(pinned_row(CMD_TICK, 16'sd0, 32'd0, 32'd499,
                                     8'd180, 1'b1, 8'd180, 1'b0, 1'b1, PROG_FULL));
        dir_tab.push_back(plain_row(CMD_SPARE7, 16'sd20, 32'd30, 32'd600));
        dir_tab.push_back(pinned_row(CMD_DETACH, 16'sd0, 32'd0, 32'd600,
                                     8'd180, 1'b0, 8'd180, 1'b0, 1'b0, PROG_FULL));
        dir_tab.push_back(plain_row(CMD_SWEEP, 16'sd20, 32'd100, 32'd601));
        // re-attach while already idle, then a sweep cut short by a set
        dir_tab.push_back(pinned_row(CMD_ATTACH, 16'sd90, 32'd0, 32'd700,
                                     8'd90, 1'b1, 8'd90, 1'b0, 1'b1, PROG_FULL));
        dir_tab.push_back(plain_row(CMD_SWEEP, 16'sd0, 32'd1000, 32'd0));
        dir_tab.push_back(plain_row(CMD_TICK, 16'sd0, 32'd0, 32'd999));
        dir_tab.push_back(pinned_row(CMD_SET, 16'sd200, 32'd0, 32'd1000,
                                     8'd180, 1'b1, 8'd180, 1'b0, 1'b1, PROG_FULL));
        // downward sweep from a clamped negative request
        dir_tab.push_back(plain_row(CMD_SWEEP, -16'sd5, 32'd9, 32'd77));
        dir_tab.push_back(plain_row(CMD_TICK, 16'sd0, 32'd0, 32'd82));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_limits(MIN_ANGLE_RST, MAX_ANGLE_RST, DEFAULT_ANGLE_RST);

        rx_idle_pct <= 14;
        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            offer_word(r.cmd, r.req, r.dur, r.now, r.pinned, r.val);
        end

        // Random phases: new limits each time, idling shifts from sender-light to
        // receiver-light to none.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       begin lo = 8'd0;   hi = 8'd180; end
                1:       begin lo = 8'd30;  hi = 8'd150; end
                2:       begin lo = 8'd120; hi = 8'd60;  end   // floor above ceiling
                3:       begin lo = 8'd90;  hi = 8'd180; end
                default: begin
                    lo = 8'($urandom_range(180));
                    hi = 8'($urandom_range(180));
                end
            endcase
            program_limits(lo, hi, 8'($urandom_range(180)));
            if (ph < 2) begin
                tx_idle_pct = 14;
                rx_idle_pct <= 65;
            end else if (ph < 4) begin
                tx_idle_pct = 65;
                rx_idle_pct <= 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // one long receiver hold while words keep coming
                if (ph == 0 && k == 40)
                    hold_arm <= 1'b1;
                roll_word(cmd, req, dur, now);
                offer_word(cmd, req, dur, now, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d command words: tick %0d, set %0d, sweep %0d, stop %0d, attach %0d, detach %0d, spare %0d",
                 cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3] + cmd_seen[4]
                 + cmd_seen[5] + cmd_seen[6] + cmd_seen[7],
                 cmd_seen[CMD_TICK], cmd_seen[CMD_SET], cmd_seen[CMD_SWEEP],
                 cmd_seen[CMD_STOP], cmd_seen[CMD_ATTACH], cmd_seen[CMD_DETACH],
                 cmd_seen[CMD_SPARE6] + cmd_seen[CMD_SPARE7]);
        $display("%0d result words checked, %0d with a write strobe, over %0d limit settings",
                 checked_count, strobe_count, RANDOM_PHASES + 1);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
